### rtl/ssg_pkg.sv
// Shared constants, direction-table seeds and types for the Sobol sequence generator.
`timescale 1ns / 1ps

package ssg_pkg;

   localparam int SSG_MAX_DIMS  = 32;
   localparam int SSG_WORD_BITS = 32;
   localparam int SSG_TAB_DIMS  = 40;

   localparam logic [31:0] SSG_HASH_DIM = 32'd2654435761;
   localparam logic [31:0] SSG_HASH_BIT = 32'd1597334677;

   // Degree of the primitive polynomial for each tabulated dimension.
   localparam logic [3:0] SSG_POLY_DEG [SSG_TAB_DIMS] = '{
      4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5,
      4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8
   };

   // Inner coefficients of each polynomial, most significant term first.
   localparam logic [7:0] SSG_POLY_COEF [SSG_TAB_DIMS] = '{
      8'd0,  8'd1,  8'd1,  8'd2,  8'd1,  8'd4,  8'd2,  8'd4,  8'd7,  8'd11,
      8'd13, 8'd14, 8'd1,  8'd13, 8'd16, 8'd19, 8'd22, 8'd25, 8'd1,  8'd4,
      8'd7,  8'd8,  8'd14, 8'd19, 8'd21, 8'd28, 8'd31, 8'd32, 8'd37, 8'd41,
      8'd42, 8'd50, 8'd55, 8'd56, 8'd59, 8'd62, 8'd14, 8'd21, 8'd22, 8'd38
   };

   // Initial odd numbers m_k of each tabulated dimension.
   localparam logic [7:0] SSG_INIT_M [SSG_TAB_DIMS][8] = '{
      '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd3, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd3, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd3, 8'd5, 8'd13, 8'd7, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd5, 8'd5, 8'd21, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd3, 8'd1, 8'd15, 8'd21, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd3, 8'd7, 8'd5, 8'd27, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd5, 8'd11, 8'd19, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd3, 8'd5, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd1, 8'd3, 8'd29, 8'd15, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd3, 8'd7, 8'd7, 8'd49, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd1, 8'd9, 8'd19, 8'd21, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd1, 8'd13, 8'd21, 8'd55, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd7, 8'd5, 8'd7, 8'd11, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd7, 8'd7, 8'd31, 8'd17, 8'd0, 8'd0},
      '{8'd1, 8'd3, 8'd7, 8'd13, 8'd1, 8'd5, 8'd49, 8'd0},
      '{8'd1, 8'd1, 8'd5, 8'd3, 8'd17, 8'd57, 8'd97, 8'd0},
      '{8'd1, 8'd1, 8'd7, 8'd1, 8'd7, 8'd33, 8'd73, 8'd0},
      '{8'd1, 8'd3, 8'd3, 8'd9, 8'd23, 8'd47, 8'd97, 8'd0},
      '{8'd1, 8'd3, 8'd7, 8'd5, 8'd5, 8'd27, 8'd39, 8'd0},
      '{8'd1, 8'd3, 8'd1, 8'd3, 8'd21, 8'd3, 8'd7, 8'd0},
      '{8'd1, 8'd1, 8'd5, 8'd11, 8'd29, 8'd17, 8'd117, 8'd0},
      '{8'd1, 8'd1, 8'd3, 8'd15, 8'd15, 8'd49, 8'd125, 8'd0},
      '{8'd1, 8'd3, 8'd1, 8'd11, 8'd19, 8'd7, 8'd3, 8'd0},
      '{8'd1, 8'd1, 8'd7, 8'd7, 8'd25, 8'd5, 8'd85, 8'd0},
      '{8'd1, 8'd1, 8'd7, 8'd13, 8'd29, 8'd51, 8'd107, 8'd0},
      '{8'd1, 8'd3, 8'd5, 8'd13, 8'd31, 8'd55, 8'd89, 8'd0},
      '{8'd1, 8'd1, 8'd1, 8'd5, 8'd11, 8'd51, 8'd69, 8'd0},
      '{8'd1, 8'd1, 8'd3, 8'd7, 8'd17, 8'd39, 8'd127, 8'd0},
      '{8'd1, 8'd1, 8'd1, 8'd9, 8'd1, 8'd33, 8'd83, 8'd0},
      '{8'd1, 8'd3, 8'd5, 8'd7, 8'd19, 8'd29, 8'd73, 8'd0},
      '{8'd1, 8'd3, 8'd5, 8'd5, 8'd1, 8'd37, 8'd101, 8'd0},
      '{8'd1, 8'd3, 8'd3, 8'd11, 8'd29, 8'd33, 8'd93, 8'd0},
      '{8'd1, 8'd3, 8'd1, 8'd3, 8'd25, 8'd29, 8'd127, 8'd151},
      '{8'd1, 8'd1, 8'd7, 8'd11, 8'd5, 8'd5, 8'd23, 8'd69},
      '{8'd1, 8'd3, 8'd3, 8'd1, 8'd31, 8'd51, 8'd95, 8'd243},
      '{8'd1, 8'd3, 8'd3, 8'd15, 8'd17, 8'd41, 8'd83, 8'd247}
   };

   typedef enum logic [1:0] {
      REQ_NEXT    = 2'd0,
      REQ_RESTART = 2'd1,
      REQ_SKIP    = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_NEXT,
      ST_SKIP,
      ST_EXH
   } state_type;

   typedef struct packed {
      logic [31:0] coordinate;
      logic [4:0]  dim_index;
      logic        last;
      logic        exhausted;
   } rsp_word_type;

endpackage

### rtl/ssg_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module ssg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sobol_sequence_generator.sv
// Gray-code Sobol point generator: direction memory, point memory and request sequencer.
`timescale 1ns / 1ps

// After reset the block builds its direction table in its own memory, one word per
// cycle, MAX_DIMS * WORD_BITS words in all; req_tready stays low until that is done.
// A next request then takes one read of the direction memory and one read-modify-write
// of the point memory per active dimension, and it emits one word per dimension with
// tlast on the final one; a stalled result side holds it back through a two-word
// output queue. A skip request sweeps the direction memory port once per active
// dimension and Gray-code bit and emits no word. When the counter has reached its end,
// a next request returns a single word with the exhausted flag set.
module sobol_sequence_generator
   import ssg_pkg::*;
#(
   parameter int MAX_DIMS  = SSG_MAX_DIMS,
   parameter int WORD_BITS = SSG_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: active_dims.
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] skip_amount
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] coordinate, [36:32] dim_index, [39:37] zero
   output logic        rsp_tlast,   // last
   output logic [0:0]  rsp_tuser    // [0] exhausted
);

   localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DIR_DEPTH = MAX_DIMS * WORD_BITS;
   localparam int DA_W      = $clog2(DIR_DEPTH);
   localparam int BIT_W     = $clog2(WORD_BITS);

   // Control state.
   state_type            state_ff, state_in;
   logic [5:0]           active_dims_ff, active_dims_in;
   logic [WORD_BITS-1:0] counter_ff, counter_in;
   logic [MAX_DIMS-1:0]  pt_vld_ff, pt_vld_in;
   logic [DIM_W-1:0]     d_ff, d_in;
   logic [BIT_W-1:0]     b_ff, b_in;
   logic [DA_W-1:0]      addr_ff, addr_in;

   // Per-request payload.
   logic [WORD_BITS-1:0] diff_ff, diff_in;
   logic [BIT_W-1:0]     c_ff, c_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] hist_ff [8];
   logic [WORD_BITS-1:0] hist_in [8];

   // Stage after the memory reads.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_skip_ff, s1_skip_in;
   logic             s1_first_ff, s1_first_in;
   logic             s1_lastbit_ff, s1_lastbit_in;
   logic             s1_sel_ff, s1_sel_in;
   logic             s1_lastdim_ff, s1_lastdim_in;
   logic             s1_ptv_ff, s1_ptv_in;
   logic [DIM_W-1:0] s1_dim_ff, s1_dim_in;

   // Output queue.
   rsp_word_type ent_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   fifo_cnt_ff, fifo_cnt_in;

   // Memory ports.
   logic                 dir_wr_en, dir_rd_en;
   logic [DA_W-1:0]      dir_rd_addr;
   logic [WORD_BITS-1:0] dir_wr_data, dir_rd_data;
   logic                 pt_wr_en, pt_rd_en;
   logic [DIM_W-1:0]     pt_rd_addr;
   logic [WORD_BITS-1:0] pt_rd_data;

   logic                 req_accept, push, pop, space_ok;
   logic                 push_next, push_exh;
   rsp_word_type         push_word;
   logic [DIM_W-1:0]     last_dim;
   logic [6:0]           eff_dims;
   logic [WORD_BITS-1:0] new_word, pt_val, dir_term;
   logic [WORD_BITS-1:0] onehot, next_cnt;
   logic [BIT_W-1:0]     c_enc;
   logic [32:0]          sum33, tgt33;
   logic [WORD_BITS-1:0] tgt_w;

   // Direction table generation.
   logic [5:0]           tab_idx;
   logic [3:0]           deg;
   logic [7:0]           coef;
   logic [BIT_W-1:0]     shift;
   logic [31:0]          m32, h32, hs32;
   logic [WORD_BITS-1:0] base_w, init_v;

   ssg_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DIR_DEPTH)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr_en),
      .wr_addr (addr_ff),
      .wr_data (dir_wr_data),
      .rd_en   (dir_rd_en),
      .rd_addr (dir_rd_addr),
      .rd_data (dir_rd_data)
   );

   ssg_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_DIMS)
   ) u_pt_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (s1_dim_ff),
      .wr_data (new_word),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && !s1_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   assign eff_dims = (active_dims_ff == 6'd0) ? 7'd1 :
                     ((7'(active_dims_ff) > 7'(MAX_DIMS)) ? 7'(MAX_DIMS) : 7'(active_dims_ff));
   assign last_dim = DIM_W'(eff_dims - 7'd1);

   // The position of the rightmost zero bit of the counter, as a one-hot word, then encoded.
   assign next_cnt = counter_ff + 1'b1;
   assign onehot   = ~counter_ff & next_cnt;

   always_comb begin
      c_enc = '0;
      for (int i = 0; i < BIT_W; i++) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            if (((j >> i) & 1) != 0) begin
               c_enc[i] = c_enc[i] | onehot[j];
            end
         end
      end
   end

   // Skip target, saturated at the last count the word can hold.
   assign sum33 = 33'(counter_ff) + 33'(req_tdata);
   assign tgt33 = (sum33 > 33'({WORD_BITS{1'b1}})) ? 33'({WORD_BITS{1'b1}}) : sum33;
   assign tgt_w = tgt33[WORD_BITS-1:0];

   // One direction word of the table build: powers of two, the initial odd numbers or the
   // polynomial recurrence, or the hashed fallback for dimensions past the tabulated ones.
   always_comb begin
      tab_idx = (7'(d_ff) < 7'(SSG_TAB_DIMS)) ? 6'(d_ff) : 6'd0;
      deg     = SSG_POLY_DEG[tab_idx];
      coef    = SSG_POLY_COEF[tab_idx];
      shift   = BIT_W'(WORD_BITS - 1) - b_ff;
      m32     = 32'(SSG_INIT_M[tab_idx][b_ff[2:0]]) << shift;
      h32     = (32'(d_ff) * SSG_HASH_DIM) ^ (32'(b_ff) * SSG_HASH_BIT);
      hs32    = (h32 << shift) | (32'd1 << shift);
      base_w  = hist_ff[3'(deg - 4'd1)];
      if (d_ff == '0) begin
         init_v = WORD_BITS'(1) << shift;
      end else if (7'(d_ff) < 7'(SSG_TAB_DIMS)) begin
         if (6'(b_ff) < 6'(deg)) begin
            init_v = m32[WORD_BITS-1:0];
         end else begin
            init_v = base_w ^ (base_w >> deg);
            for (int j = 1; j < 8; j++) begin
               if ((4'(j) < deg) && coef[3'(deg - 4'd1 - 4'(j))]) begin
                  init_v = init_v ^ hist_ff[j-1];
               end
            end
         end
      end else begin
         init_v = hs32[WORD_BITS-1:0];
      end
   end

   assign dir_wr_data = init_v;

   // Result of the read stage: fold the direction word into the point word.
   assign pt_val    = s1_ptv_ff ? pt_rd_data : '0;
   assign dir_term  = (s1_skip_ff && !s1_sel_ff) ? '0 : dir_rd_data;
   assign new_word  = ((!s1_skip_ff || s1_first_ff) ? pt_val : acc_ff) ^ dir_term;
   assign pt_wr_en  = s1_valid_ff && (!s1_skip_ff || s1_lastbit_ff);
   assign push_next = s1_valid_ff && !s1_skip_ff;

   // A read may issue only if its word will find room in the output queue.
   assign pop      = rsp_tvalid && rsp_tready;
   assign space_ok = (3'(fifo_cnt_ff) + 3'(s1_valid_ff)) <= (3'(pop) + 3'd1);

   always_comb begin
      state_in       = state_ff;
      active_dims_in = csr_wr_en ? csr_wr_data : active_dims_ff;
      counter_in     = counter_ff;
      pt_vld_in      = pt_vld_ff;
      d_in           = d_ff;
      b_in           = b_ff;
      addr_in        = addr_ff;
      diff_in        = diff_ff;
      c_in           = c_ff;
      acc_in         = acc_ff;
      hist_in        = hist_ff;
      s1_valid_in    = 1'b0;
      s1_skip_in     = s1_skip_ff;
      s1_first_in    = s1_first_ff;
      s1_lastbit_in  = s1_lastbit_ff;
      s1_sel_in      = s1_sel_ff;
      s1_lastdim_in  = s1_lastdim_ff;
      s1_ptv_in      = s1_ptv_ff;
      s1_dim_in      = s1_dim_ff;
      dir_wr_en      = 1'b0;
      dir_rd_en      = 1'b0;
      dir_rd_addr    = addr_ff;
      pt_rd_en       = 1'b0;
      pt_rd_addr     = d_ff;
      push_exh       = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            dir_wr_en  = 1'b1;
            hist_in[0] = init_v;
            for (int i = 1; i < 8; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            addr_in = addr_ff + 1'b1;
            if (b_ff == BIT_W'(WORD_BITS - 1)) begin
               b_in = '0;
               d_in = d_ff + 1'b1;
            end else begin
               b_in = b_ff + 1'b1;
            end
            if (addr_ff == DA_W'(DIR_DEPTH - 1)) begin
               addr_in  = '0;
               b_in     = '0;
               d_in     = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_code_type'(req_tuser))
                  REQ_NEXT: begin
                     if (counter_ff == {WORD_BITS{1'b1}}) begin
                        state_in = ST_EXH;
                     end else begin
                        c_in     = c_enc;
                        addr_in  = '0;
                        d_in     = '0;
                        state_in = ST_NEXT;
                     end
                  end
                  REQ_RESTART: begin
                     pt_vld_in  = '0;
                     counter_in = '0;
                  end
                  REQ_SKIP: begin
                     diff_in    = (counter_ff ^ (counter_ff >> 1)) ^ (tgt_w ^ (tgt_w >> 1));
                     counter_in = tgt_w;
                     addr_in    = '0;
                     d_in       = '0;
                     b_in       = '0;
                     state_in   = ST_SKIP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NEXT: begin
            if (space_ok) begin
               dir_rd_en     = 1'b1;
               dir_rd_addr   = addr_ff + DA_W'(c_ff);
               pt_rd_en      = 1'b1;
               s1_valid_in   = 1'b1;
               s1_skip_in    = 1'b0;
               s1_dim_in     = d_ff;
               s1_lastdim_in = (d_ff == last_dim);
               s1_ptv_in     = pt_vld_ff[d_ff];
               d_in          = d_ff + 1'b1;
               addr_in       = addr_ff + DA_W'(WORD_BITS);
               if (d_ff == last_dim) begin
                  counter_in = next_cnt;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_SKIP: begin
            dir_rd_en     = 1'b1;
            pt_rd_en      = (b_ff == '0);
            s1_valid_in   = 1'b1;
            s1_skip_in    = 1'b1;
            s1_first_in   = (b_ff == '0);
            s1_lastbit_in = (b_ff == BIT_W'(WORD_BITS - 1));
            s1_sel_in     = diff_ff[b_ff];
            s1_dim_in     = d_ff;
            s1_ptv_in     = pt_vld_ff[d_ff];
            addr_in       = addr_ff + 1'b1;
            if (b_ff == BIT_W'(WORD_BITS - 1)) begin
               b_in = '0;
               d_in = d_ff + 1'b1;
               if (d_ff == last_dim) begin
                  state_in = ST_IDLE;
               end
            end else begin
               b_in = b_ff + 1'b1;
            end
         end
         ST_EXH: begin
            if (space_ok) begin
               push_exh = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (s1_valid_ff && s1_skip_ff) begin
         acc_in = new_word;
      end
      if (pt_wr_en) begin
         pt_vld_in[s1_dim_ff] = 1'b1;
      end
   end

   // Output queue bookkeeping.
   assign push = push_next || push_exh;

   always_comb begin
      push_word.coordinate = 32'(new_word) << (32 - WORD_BITS);
      push_word.dim_index  = 5'(s1_dim_ff);
      push_word.last       = s1_lastdim_ff;
      push_word.exhausted  = 1'b0;
      if (push_exh) begin
         push_word.coordinate = '0;
         push_word.dim_index  = '0;
         push_word.last       = 1'b1;
         push_word.exhausted  = 1'b1;
      end
      fifo_cnt_in = fifo_cnt_ff + 2'(push) - 2'(pop);
   end

   assign rsp_tvalid = (fifo_cnt_ff != 2'd0);
   assign rsp_tdata  = {3'b000, ent_ff[rd_ptr_ff].dim_index, ent_ff[rd_ptr_ff].coordinate};
   assign rsp_tlast  = ent_ff[rd_ptr_ff].last;
   assign rsp_tuser  = ent_ff[rd_ptr_ff].exhausted;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         active_dims_ff <= 6'd1;
         counter_ff     <= '0;
         pt_vld_ff      <= '0;
         d_ff           <= '0;
         b_ff           <= '0;
         addr_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         fifo_cnt_ff    <= '0;
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_dims_ff <= active_dims_in;
         counter_ff     <= counter_in;
         pt_vld_ff      <= pt_vld_in;
         d_ff           <= d_in;
         b_ff           <= b_in;
         addr_ff        <= addr_in;
         s1_valid_ff    <= s1_valid_in;
         fifo_cnt_ff    <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      c_ff          <= c_in;
      acc_ff        <= acc_in;
      hist_ff       <= hist_in;
      s1_skip_ff    <= s1_skip_in;
      s1_first_ff   <= s1_first_in;
      s1_lastbit_ff <= s1_lastbit_in;
      s1_sel_ff     <= s1_sel_in;
      s1_lastdim_ff <= s1_lastdim_in;
      s1_ptv_ff     <= s1_ptv_in;
      s1_dim_ff     <= s1_dim_in;
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### tb/testbench.sv
// Self-checking testbench for the Gray-code Sobol sequence generator.
`timescale 1ns / 1ps

module testbench
   import ssg_pkg::*;
();

   localparam int CLK_HALF_NS   = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int NUM_DIMS      = 32;
   localparam int NUM_BITS      = 32;
   // A skip over all dimensions sweeps 32 x 32 words; this covers it with margin.
   localparam int SETTLE_CYCLES = 1100;
   localparam int PHASE_ITEMS   = 32;
   localparam int NUM_PHASES    = 8;
   localparam longint RUN_LIMIT_NS = 64'd36_000_000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Primitive polynomial degree, inner coefficients and initial odd numbers per dimension.
   localparam int POLY_DEGREE [NUM_DIMS] = '{
      1, 2, 3, 3, 4, 4, 5, 5, 5, 5, 5, 5, 6, 6, 6, 6,
      6, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7
   };
   localparam int POLY_TERMS [NUM_DIMS] = '{
      0, 1, 1, 2, 1, 4, 2, 4, 7, 11, 13, 14, 1, 13, 16, 19,
      22, 25, 1, 4, 7, 8, 14, 19, 21, 28, 31, 32, 37, 41, 42, 50
   };
   localparam int START_ODD [NUM_DIMS][7] = '{
      '{1, 0, 0, 0, 0, 0, 0},       '{1, 1, 0, 0, 0, 0, 0},
      '{1, 3, 1, 0, 0, 0, 0},       '{1, 3, 3, 0, 0, 0, 0},
      '{1, 1, 1, 1, 0, 0, 0},       '{1, 1, 3, 3, 0, 0, 0},
      '{1, 3, 5, 13, 7, 0, 0},      '{1, 1, 5, 5, 21, 0, 0},
      '{1, 3, 1, 15, 21, 0, 0},     '{1, 3, 7, 5, 27, 0, 0},
      '{1, 1, 5, 11, 19, 0, 0},     '{1, 3, 5, 1, 1, 0, 0},
      '{1, 1, 1, 3, 29, 15, 0},     '{1, 1, 3, 7, 7, 49, 0},
      '{1, 1, 1, 9, 19, 21, 0},     '{1, 1, 1, 13, 21, 55, 0},
      '{1, 1, 7, 5, 7, 11, 0},      '{1, 1, 7, 7, 31, 17, 0},
      '{1, 3, 7, 13, 1, 5, 49},     '{1, 1, 5, 3, 17, 57, 97},
      '{1, 1, 7, 1, 7, 33, 73},     '{1, 3, 3, 9, 23, 47, 97},
      '{1, 3, 7, 5, 5, 27, 39},     '{1, 3, 1, 3, 21, 3, 7},
      '{1, 1, 5, 11, 29, 17, 117},  '{1, 1, 3, 15, 15, 49, 125},
      '{1, 3, 1, 11, 19, 7, 3},     '{1, 1, 7, 7, 25, 5, 85},
      '{1, 1, 7, 13, 29, 51, 107},  '{1, 3, 5, 13, 31, 55, 89},
      '{1, 1, 1, 5, 11, 51, 69},    '{1, 1, 3, 7, 17, 39, 127}
   };

   typedef struct packed {
      logic [31:0] coord;
      logic [4:0]  dim;
      logic        last;
      logic        exhausted;
   } coord_word_type;

   typedef struct packed {
      logic [1:0]  code;
      logic [31:0] amount;
      logic        known;
      logic [31:0] coord;
      logic        exhausted;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = 6'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   logic [31:0]    dir_words [NUM_DIMS][NUM_BITS];
   logic [31:0]    point_acc [NUM_DIMS];
   logic [31:0]    step_count;
   logic [5:0]     dims_setting;
   coord_word_type pending_coords [$];
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;
   int             errors = 0;

   // Rows with a typed coordinate run with one dimension, so each yields a single word.
   stim_row_type directed_rows [25] = '{
      '{REQ_NEXT,    32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{REQ_NEXT,    32'hFFFF_FFFF, 1'b1, 32'hC000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b1, 32'h4000_0000, 1'b0},
      '{REQ_UNUSED,  32'h0000_0003, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b1, 32'h6000_0000, 1'b0},
      '{REQ_RESTART, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{REQ_SKIP,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_SKIP,    32'h0000_0005, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_SKIP,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{REQ_NEXT,    32'h5555_AAAA, 1'b1, 32'h0000_0000, 1'b1},
      '{REQ_SKIP,    32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{REQ_RESTART, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_SKIP,    32'h7FFF_FFFE, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_SKIP,    32'h7FFF_FFFD, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_NEXT,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{REQ_UNUSED,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
      '{REQ_RESTART, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}
   };

   sobol_sequence_generator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always #(CLK_HALF_NS) clock = ~clock;

   function automatic void build_directions();
      int deg;
      int terms;
      logic [31:0] seed;
      logic [31:0] v;
      for (int d = 0; d < NUM_DIMS; d++) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            if (d == 0) begin
               v = 32'h1 << (31 - k);
            end else begin
               deg = POLY_DEGREE[d];
               terms = POLY_TERMS[d];
               if (k < deg) begin
                  seed = START_ODD[d][k];
                  v = seed << (31 - k);
               end else begin
                  v = dir_words[d][k - deg] ^ (dir_words[d][k - deg] >> deg);
                  for (int j = 1; j < deg; j++) begin
                     if ((terms >> (deg - 1 - j)) & 1) begin
                        v = v ^ dir_words[d][k - j];
                     end
                  end
               end
            end
            dir_words[d][k] = v;
         end
      end
   endfunction

   function automatic int dims_in_effect();
      if (dims_setting == 6'd0) begin
         return 1;
      end
      return (dims_setting > NUM_DIMS) ? NUM_DIMS : int'(dims_setting);
   endfunction

   function automatic logic [31:0] gray_of(logic [31:0] x);
      return x ^ (x >> 1);
   endfunction

   // Advances the generator state for one request and queues the words it should emit.
   function automatic void advance_sequence(logic [1:0] code, logic [31:0] amount);
      int n;
      int c;
      logic [32:0] target;
      logic [31:0] flips;
      coord_word_type w;
      n = dims_in_effect();
      unique case (code)
         REQ_NEXT: begin
            if (step_count == 32'hFFFF_FFFF) begin
               w = '{32'd0, 5'd0, 1'b1, 1'b1};
               pending_coords.push_back(w);
            end else begin
               c = 0;
               while (c < NUM_BITS - 1 && step_count[c]) begin
                  c++;
               end
               for (int d = 0; d < n; d++) begin
                  point_acc[d] = point_acc[d] ^ dir_words[d][c];
                  w = '{point_acc[d], d[4:0], (d == n - 1), 1'b0};
                  pending_coords.push_back(w);
               end
               step_count = step_count + 32'd1;
            end
         end
         REQ_RESTART: begin
            for (int d = 0; d < NUM_DIMS; d++) begin
               point_acc[d] = 32'd0;
            end
            step_count = 32'd0;
         end
         REQ_SKIP: begin
            target = {1'b0, step_count} + {1'b0, amount};
            if (target > 33'h0_FFFF_FFFF) begin
               target = 33'h0_FFFF_FFFF;
            end
            flips = gray_of(step_count) ^ gray_of(target[31:0]);
            for (int b = 0; b < NUM_BITS; b++) begin
               if (flips[b]) begin
                  for (int d = 0; d < n; d++) begin
                     point_acc[d] = point_acc[d] ^ dir_words[d][b];
                  end
               end
            end
            step_count = target[31:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows
   // acceptance. Expectations are queued there, away from the edge that pops them.
   task automatic send_request(logic [1:0] code, logic [31:0] amount, logic known,
                               logic [31:0] coord, logic exhausted);
      coord_word_type w;
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = code;
      req_tdata = amount;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
      advance_sequence(code, amount);
      if (known) begin
         void'(pending_coords.pop_back());
         w = '{coord, 5'd0, 1'b1, exhausted};
         pending_coords.push_back(w);
      end
   endtask

   task automatic wait_idle();
      while (pending_coords.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_dims(logic [5:0] value);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      dims_setting = value;
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      coord_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_coords.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_coords.pop_front();
            if (rsp_tdata[31:0] !== want.coord) begin
               $display("%0t: coordinate expected %h got %h",
                        $time, want.coord, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[36:32] !== want.dim) begin
               $display("%0t: dim_index expected %0d got %0d",
                        $time, want.dim, rsp_tdata[36:32]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b got %b", $time, want.last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser[0] !== want.exhausted) begin
               $display("%0t: exhausted expected %b got %b",
                        $time, want.exhausted, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("sobol_sequence_generator verification failed");
      $finish;
   end

   initial begin
      logic [5:0]  dims_plan [NUM_PHASES];
      logic [1:0]  code;
      logic [31:0] amount;
      int          pick;
      int          counted;
      build_directions();
      for (int d = 0; d < NUM_DIMS; d++) begin
         point_acc[d] = 32'd0;
      end
      step_count = 32'd0;
      dims_setting = 6'd1;
      dims_plan = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'(2 + $urandom_range(0, 29)),
                    6'($urandom_range(0, 63)), 6'd17};

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Directed rows run on the reset value of active_dims.
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].code, directed_rows[i].amount,
                      directed_rows[i].known, directed_rows[i].coord,
                      directed_rows[i].exhausted);
      end
      req_tvalid = 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         write_dims(dims_plan[phase]);
         unique case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
            default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            amount = $urandom;
            if (pick < 58) begin
               code = REQ_NEXT;
            end else if (pick < 66) begin
               code = REQ_RESTART;
            end else if (pick < 92) begin
               code = REQ_SKIP;
               // Mostly short hops; some reach into high counter bits or saturate.
               pick = $urandom_range(0, 9);
               if (pick < 5) begin
                  amount = $urandom_range(0, 20);
               end else if (pick < 8) begin
                  amount = amount >> $urandom_range(1, 31);
               end
            end else begin
               code = REQ_UNUSED;
            end
            send_request(code, amount, 1'b0, 32'd0, 1'b0);
            if (code != REQ_UNUSED) begin
               counted++;
            end
         end
         req_tvalid = 1'b0;
      end

      wait_idle();
      if (errors == 0) begin
         $display("sobol_sequence_generator verification clean");
      end else begin
         $display("sobol_sequence_generator verification failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/ssg_pkg.sv
rtl/ssg_ram.sv
rtl/sobol_sequence_generator.sv
tb/testbench.sv
